[design/usi_pkg.sv]
// Shared types, codes and helper functions of the universal serial interface.
`timescale 1ns / 1ps

package usi_pkg;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_REG_WRITE  = 2'd0,
        KIND_TIMER      = 2'd1,
        KIND_CLOCK_PIN  = 2'd2,
        KIND_DATA_PIN   = 2'd3
    } usi_kind_t;

    // Register select codes
    typedef enum logic [1:0] {
        REG_CONTROL = 2'd0,
        REG_STATUS  = 2'd1,
        REG_SHIFT   = 2'd2
    } usi_reg_sel_t;

    typedef enum logic [1:0] {
        WIRE_OFF      = 2'd0,
        WIRE_THREE    = 2'd1,
        WIRE_TWO      = 2'd2,
        WIRE_TWO_HOLD = 2'd3
    } usi_wire_mode_t;

    typedef enum logic [1:0] {
        CLK_STROBE   = 2'd0,
        CLK_TIMER    = 2'd1,
        CLK_EXT_RISE = 2'd2,
        CLK_EXT_FALL = 2'd3
    } usi_clock_mode_t;

    localparam int DATA_W  = 8;
    localparam int COUNT_W = 4;

    // Control register bit positions
    localparam int CTRL_START_IE = 7;
    localparam int CTRL_OVF_IE   = 6;
    localparam int CTRL_WM_HI    = 5;
    localparam int CTRL_WM_LO    = 4;
    localparam int CTRL_CS_HI    = 3;
    localparam int CTRL_CS_LO    = 2;
    localparam int CTRL_STROBE   = 1;
    localparam int CTRL_TOGGLE   = 0;

    // Status register bit positions
    localparam int STAT_START = 7;
    localparam int STAT_OVF   = 6;
    localparam int STAT_STOP  = 5;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         reg_sel;
        logic [DATA_W-1:0]  write_data;
        logic               timer_match_a;
        logic               clock_pin;
        logic               data_pin;
    } usi_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]  shift;
        logic [DATA_W-1:0]  buffer;
        logic [COUNT_W-1:0] count;
        usi_clock_mode_t    clock_mode;
        usi_wire_mode_t     wire_mode;
        logic               strobe;
        logic               flag_ovf;
        logic               flag_start;
        logic               flag_stop;
        logic               ovf_ie;
        logic               start_ie;
        logic               start_seen;
        logic               hold;
        logic               ld_clk;
        logic               ld_do;
        logic               ld_sda;
    } usi_state_t;

    typedef struct packed {
        logic [DATA_W-1:0]  data_reg;
        logic [DATA_W-1:0]  buffer_reg;
        logic [COUNT_W-1:0] counter;
        logic               ovf_flag;
        logic               start_flag;
        logic               stop_flag;
        logic               clk_line;
        logic               do_line;
        logic               sda_line;
        logic               clock_hold;
        logic               ovf_irq;
        logic               start_irq;
    } usi_result_t;

    function automatic logic is_two_wire(input usi_wire_mode_t m);
        return (m == WIRE_TWO) || (m == WIRE_TWO_HOLD);
    endfunction

    // Output latch closed: rising mode with clock low, falling mode with clock high
    function automatic logic is_latched(input usi_clock_mode_t cm, input logic clk_lvl);
        return ((cm == CLK_EXT_RISE) && !clk_lvl) || ((cm == CLK_EXT_FALL) && clk_lvl);
    endfunction

endpackage

[design/usi_if.sv]
// Valid/ready channels carrying input items and result items.
`timescale 1ns / 1ps

interface usi_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] reg_sel;
    logic [7:0] write_data;
    logic       timer_match_a;
    logic       clock_pin;
    logic       data_pin;

    modport source (output valid, kind, reg_sel, write_data, timer_match_a, clock_pin,
                    data_pin, input ready);
    modport sink   (input valid, kind, reg_sel, write_data, timer_match_a, clock_pin,
                    data_pin, output ready);
endinterface

interface usi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_reg;
    logic [7:0] buffer_reg;
    logic [3:0] counter;
    logic       ovf_flag;
    logic       start_flag;
    logic       stop_flag;
    logic       clk_line;
    logic       do_line;
    logic       sda_line;
    logic       clock_hold;
    logic       ovf_irq;
    logic       start_irq;

    modport source (output valid, data_reg, buffer_reg, counter, ovf_flag, start_flag,
                    stop_flag, clk_line, do_line, sda_line, clock_hold, ovf_irq,
                    start_irq, input ready);
    modport sink   (input valid, data_reg, buffer_reg, counter, ovf_flag, start_flag,
                    stop_flag, clk_line, do_line, sda_line, clock_hold, ovf_irq,
                    start_irq, output ready);
endinterface

[design/usi_step.sv]
// Event logic: next state of the shift engine for one item.
`timescale 1ns / 1ps

module usi_step
    import usi_pkg::*;
(
    input  usi_state_t state_cur,
    input  usi_item_t  item,
    output usi_state_t state_next
);

    // Drive the shift register MSB onto the active data line
    function automatic usi_state_t drive_msb(input usi_state_t s);
        usi_state_t r;
        r = s;
        if (s.wire_mode == WIRE_THREE)
            r.ld_do = s.shift[DATA_W-1];
        else if (s.wire_mode != WIRE_OFF)
            r.ld_sda = s.shift[DATA_W-1];
        return r;
    endfunction

    // Advance the edge counter; on wrap copy to buffer, flag overflow and, in hold mode, hold the clock
    function automatic usi_state_t count_edge(input usi_state_t s);
        usi_state_t r;
        r = s;
        r.count = s.count + COUNT_W'(1);
        if (r.count == '0)
        begin
            r.buffer   = s.shift;
            r.flag_ovf = 1'b1;
            if (s.wire_mode == WIRE_TWO_HOLD)
                r.hold = 1'b1;
        end
        return r;
    endfunction

    usi_state_t      s;
    usi_wire_mode_t  wm_new;
    usi_clock_mode_t cm_new;
    logic            was_latched;
    logic            ovf_after;
    logic            shift_edge;
    logic [DATA_W-1:0] v;

    always_comb
    begin
        s           = state_cur;
        v           = item.write_data;
        wm_new      = usi_wire_mode_t'(v[CTRL_WM_HI:CTRL_WM_LO]);
        cm_new      = usi_clock_mode_t'(v[CTRL_CS_HI:CTRL_CS_LO]);
        was_latched = 1'b0;
        ovf_after   = 1'b0;
        shift_edge  = 1'b0;

        unique case (usi_kind_t'(item.kind))
            KIND_REG_WRITE:
            begin
                case (item.reg_sel)
                    REG_CONTROL:
                    begin
                        // Wire mode change: update the data line, drop two-wire state outside two-wire modes
                        if (wm_new != s.wire_mode)
                        begin
                            s.wire_mode = wm_new;
                            if (!is_latched(s.clock_mode, item.clock_pin))
                                s = drive_msb(s);
                            if (!is_two_wire(wm_new))
                            begin
                                s.hold       = 1'b0;
                                s.start_seen = 1'b0;
                            end
                        end
                        // Clock mode change: release the output latch if it opens
                        was_latched  = is_latched(s.clock_mode, item.clock_pin);
                        s.clock_mode = cm_new;
                        if (was_latched && !is_latched(cm_new, item.clock_pin))
                            s = drive_msb(s);
                        s.ovf_ie   = v[CTRL_OVF_IE];
                        s.start_ie = v[CTRL_START_IE];
                        s.strobe   = v[CTRL_STROBE];
                        // Strobe in strobe mode: shift, drive, count, self-clear
                        if ((cm_new == CLK_STROBE) && s.strobe)
                        begin
                            s.shift  = {s.shift[DATA_W-2:0], item.data_pin};
                            s        = drive_msb(s);
                            s        = count_edge(s);
                            s.strobe = 1'b0;
                        end
                        // Clock toggle; counts in external modes when strobe is set
                        if (v[CTRL_TOGGLE])
                        begin
                            s.ld_clk = ~s.ld_clk;
                            if (((cm_new == CLK_EXT_RISE) || (cm_new == CLK_EXT_FALL))
                                && s.strobe)
                                s = count_edge(s);
                        end
                    end
                    REG_STATUS:
                    begin
                        ovf_after = v[STAT_OVF] ? 1'b0 : s.flag_ovf;
                        if ((v[STAT_OVF] && (s.wire_mode == WIRE_TWO_HOLD) && !s.flag_start)
                            || (v[STAT_START] && ((s.wire_mode == WIRE_TWO)
                                || ((s.wire_mode == WIRE_TWO_HOLD) && !ovf_after))))
                            s.hold = 1'b0;
                        if (v[STAT_OVF])
                            s.flag_ovf = 1'b0;
                        if (v[STAT_START])
                        begin
                            s.flag_start = 1'b0;
                            s.start_seen = 1'b0;
                        end
                        if (v[STAT_STOP])
                            s.flag_stop = 1'b0;
                        s.count = v[COUNT_W-1:0];
                    end
                    REG_SHIFT:
                    begin
                        s.shift = v;
                        if (!is_latched(s.clock_mode, item.clock_pin))
                            s = drive_msb(s);
                    end
                    default:
                    begin
                        s = state_cur;
                    end
                endcase
            end
            KIND_TIMER:
            begin
                if ((s.clock_mode == CLK_TIMER) && item.timer_match_a)
                begin
                    s.shift = {s.shift[DATA_W-2:0], item.data_pin};
                    s       = drive_msb(s);
                    s       = count_edge(s);
                end
            end
            KIND_CLOCK_PIN:
            begin
                // External clock: shift on the active edge, drive on the other
                if ((s.clock_mode == CLK_EXT_RISE) || (s.clock_mode == CLK_EXT_FALL))
                begin
                    shift_edge = (s.clock_mode == CLK_EXT_RISE) ? item.clock_pin
                                                                : !item.clock_pin;
                    if (shift_edge)
                        s.shift = {s.shift[DATA_W-2:0], item.data_pin};
                    else
                        s = drive_msb(s);
                    if (!s.strobe)
                        s = count_edge(s);
                end
                // First falling clock after a start holds the clock
                if (s.start_seen && !item.clock_pin)
                begin
                    s.start_seen = 1'b0;
                    s.hold       = 1'b1;
                end
            end
            KIND_DATA_PIN:
            begin
                // Data edge with clock high: start or stop condition
                if (is_two_wire(s.wire_mode) && item.clock_pin)
                begin
                    if (item.data_pin)
                        s.flag_stop = 1'b1;
                    else
                    begin
                        s.start_seen = 1'b1;
                        s.flag_start = 1'b1;
                    end
                end
            end
        endcase

        state_next = s;
    end

endmodule

[design/universal_serial_interface_core.sv]
// Top level of the universal serial interface shift engine.
// Each item (register write, timer event, clock pin or data pin change) yields
// exactly one result that reports the shift register, buffer, counter, flags,
// line drives, clock hold and interrupt lines after the item. The item passes
// through the input register, then the single pass of event logic, into the
// state and result registers; one item is taken per cycle while the result is
// not stalled. A stalled result stops the next item from entering the input
// register once that register holds an item. No clearing pass follows reset.
`timescale 1ns / 1ps

module universal_serial_interface_core
    import usi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    usi_in_if.sink    in_ch,
    usi_out_if.source out_ch
);

    logic        in_valid_reg;
    usi_item_t   in_item_reg;
    logic        out_valid_reg;
    usi_result_t out_reg;
    usi_result_t out_next;
    usi_state_t  state_reg;
    usi_state_t  state_next;
    logic        advance;

    // Process the held item once the result register is free
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_item_reg <= '0;
        else if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg.kind          <= in_ch.kind;
            in_item_reg.reg_sel       <= in_ch.reg_sel;
            in_item_reg.write_data    <= in_ch.write_data;
            in_item_reg.timer_match_a <= in_ch.timer_match_a;
            in_item_reg.clock_pin     <= in_ch.clock_pin;
            in_item_reg.data_pin      <= in_ch.data_pin;
        end
    end

    usi_step u_usi_step (
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .state_next (state_next)
    );

    // Engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // Assemble the result from the updated state
    always_comb
    begin
        out_next.data_reg   = state_next.shift;
        out_next.buffer_reg = state_next.buffer;
        out_next.counter    = state_next.count;
        out_next.ovf_flag   = state_next.flag_ovf;
        out_next.start_flag = state_next.flag_start;
        out_next.stop_flag  = state_next.flag_stop;
        out_next.clk_line   = state_next.ld_clk;
        out_next.do_line    = state_next.ld_do;
        out_next.sda_line   = state_next.ld_sda;
        out_next.clock_hold = state_next.hold;
        out_next.ovf_irq    = state_next.flag_ovf && state_next.ovf_ie;
        out_next.start_irq  = state_next.flag_start && state_next.start_ie;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.data_reg   = out_reg.data_reg;
    assign out_ch.buffer_reg = out_reg.buffer_reg;
    assign out_ch.counter    = out_reg.counter;
    assign out_ch.ovf_flag   = out_reg.ovf_flag;
    assign out_ch.start_flag = out_reg.start_flag;
    assign out_ch.stop_flag  = out_reg.stop_flag;
    assign out_ch.clk_line   = out_reg.clk_line;
    assign out_ch.do_line    = out_reg.do_line;
    assign out_ch.sda_line   = out_reg.sda_line;
    assign out_ch.clock_hold = out_reg.clock_hold;
    assign out_ch.ovf_irq    = out_reg.ovf_irq;
    assign out_ch.start_irq  = out_reg.start_irq;

endmodule

[design/usi_checker.sv]
// Port-level checks of the universal serial interface, bound to the top level.
`timescale 1ns / 1ps

module usi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] data_reg,
    input logic       ovf_flag,
    input logic       start_flag,
    input logic       ovf_irq,
    input logic       start_irq
);

    // Hold a stalled result
    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(data_reg))
        else $error("result data changed while stalled");

    // Interrupt lines only with their flag
    a_ovf_irq_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ovf_irq |-> ovf_flag)
        else $error("overflow interrupt without overflow flag");

    a_start_irq_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_irq |-> start_flag)
        else $error("start interrupt without start flag");

endmodule

bind universal_serial_interface_core usi_checker u_usi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .data_reg   (out_ch.data_reg),
    .ovf_flag   (out_ch.ovf_flag),
    .start_flag (out_ch.start_flag),
    .ovf_irq    (out_ch.ovf_irq),
    .start_irq  (out_ch.start_irq)
);
